// ===== hdl/rau_pkg.sv =====
`default_nettype none
package rau_pkg;

	localparam int MAG_BITS_DEF = 31;

	localparam logic [3:0] FN_ADD = 4'd0;
	localparam logic [3:0] FN_SUB = 4'd1;
	localparam logic [3:0] FN_MUL = 4'd2;
	localparam logic [3:0] FN_DIV = 4'd3;
	localparam logic [3:0] FN_LT  = 4'd4;
	localparam logic [3:0] FN_LE  = 4'd5;
	localparam logic [3:0] FN_GT  = 4'd6;
	localparam logic [3:0] FN_GE  = 4'd7;
	localparam logic [3:0] FN_EQ  = 4'd8;
	localparam logic [3:0] FN_NE  = 4'd9;

	localparam logic [1:0] MS_P = 2'd0;
	localparam logic [1:0] MS_Q = 2'd1;
	localparam logic [1:0] MS_M = 2'd2;
	localparam logic [1:0] MS_D = 2'd3;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       eval;
		logic       gcd_step;
		logic       shift_g;
		logic       div_init_num;
		logic       div_init_den;
		logic       div_step;
		logic       save_den;
		logic       load_out;
	} rau_cmd_t;

	typedef struct packed {
		logic short_res;
		logic gcd_done;
		logic div_last;
	} rau_sts_t;

endpackage
`default_nettype wire

// ===== hdl/rau_in_if.sv =====
`default_nettype none
interface rau_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  func;
	logic        a_sign;
	logic [30:0] a_num;
	logic [30:0] a_den;
	logic        b_sign;
	logic [30:0] b_num;
	logic [30:0] b_den;

	modport source (output valid, func, a_sign, a_num, a_den, b_sign, b_num, b_den,
		input ready);
	modport sink (input valid, func, a_sign, a_num, a_den, b_sign, b_num, b_den,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/rau_out_if.sv =====
`default_nettype none
interface rau_out_if;
	logic        valid;
	logic        ready;
	logic        res_sign;
	logic [62:0] res_num;
	logic [61:0] res_den;
	logic        cmp_true;
	logic        undefined;

	modport source (output valid, res_sign, res_num, res_den, cmp_true, undefined,
		input ready);
	modport sink (input valid, res_sign, res_num, res_den, cmp_true, undefined,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/rau_ctrl.sv =====
`default_nettype none
module rau_ctrl
	import rau_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire rau_sts_t sts,
	output rau_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL0  = 4'd1;
	localparam logic [3:0] S_MUL1  = 4'd2;
	localparam logic [3:0] S_MUL2  = 4'd3;
	localparam logic [3:0] S_MUL3  = 4'd4;
	localparam logic [3:0] S_EVAL  = 4'd5;
	localparam logic [3:0] S_GCD   = 4'd6;
	localparam logic [3:0] S_SHIFT = 4'd7;
	localparam logic [3:0] S_DIVN  = 4'd8;
	localparam logic [3:0] S_DIVD0 = 4'd9;
	localparam logic [3:0] S_DIVD  = 4'd10;
	localparam logic [3:0] S_SAVE  = 4'd11;
	localparam logic [3:0] S_FIN   = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL0;
				end
			end
			S_MUL0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_P;
				state_d     = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_Q;
				state_d     = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_M;
				state_d     = S_MUL3;
			end
			S_MUL3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_D;
				state_d     = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.short_res ? S_FIN : S_GCD;
			end
			S_GCD: begin
				if (sts.gcd_done) begin
					state_d = S_SHIFT;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_SHIFT: begin
				cmd.shift_g      = 1'b1;
				cmd.div_init_num = 1'b1;
				state_d          = S_DIVN;
			end
			S_DIVN: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_DIVD0;
				end
			end
			S_DIVD0: begin
				cmd.div_init_den = 1'b1;
				state_d          = S_DIVD;
			end
			S_DIVD: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_SAVE;
				end
			end
			S_SAVE: begin
				cmd.save_den = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/rau_dp.sv =====
`default_nettype none
module rau_dp
	import rau_pkg::*;
#(
	parameter int MAG_BITS = MAG_BITS_DEF
) (
	input  wire logic        clk,
	input  wire rau_cmd_t    cmd,
	output rau_sts_t         sts,
	input  wire logic [3:0]  func,
	input  wire logic        a_sign,
	input  wire logic [30:0] a_num,
	input  wire logic [30:0] a_den,
	input  wire logic        b_sign,
	input  wire logic [30:0] b_num,
	input  wire logic [30:0] b_den,
	output logic             res_sign,
	output logic [62:0]      res_num,
	output logic [61:0]      res_den,
	output logic             cmp_true,
	output logic             undefined
);

	localparam int W  = MAG_BITS;
	localparam int PW = 2 * W;
	localparam int NW = PW + 1;
	localparam int KW = $clog2(NW);
	localparam int CW = $clog2(NW);

	logic [3:0]    func_q;
	logic          a_sign_q, b_sign_q;
	logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
	logic [PW-1:0] p_q, q_q, m_q, d_q;
	logic [NW-1:0] num_q;
	logic [PW-1:0] den_q;
	logic [NW-1:0] u_q, v_q, g_q;
	logic [KW-1:0] k_q;
	logic [NW-1:0] rem_q, dvd_q, quo_q;
	logic [CW-1:0] cnt_q;
	logic          f_sign_q, f_cmp_q, f_undef_q;
	logic [NW-1:0] f_num_q;
	logic [PW-1:0] f_den_q;
	logic          o_sign_q, o_cmp_q, o_undef_q;
	logic [NW-1:0] o_num_q;
	logic [PW-1:0] o_den_q;

	logic [W-1:0]  mx, my;
	logic [PW-1:0] prod;

	always_comb begin
		case (cmd.mul_sel)
			MS_P: begin mx = an_q; my = bd_q; end
			MS_Q: begin mx = bn_q; my = ad_q; end
			MS_M: begin mx = an_q; my = bn_q; end
			default: begin mx = ad_q; my = bd_q; end
		endcase
		prod = PW'(mx) * PW'(my);
	end

	logic          arith, is_cmp, bad, adz, bdz, bnz;
	logic          sbe, p_ge, ln, rneg, lt, eq, cmp, s_e, short_res;
	logic [NW-1:0] num_e, sum, diff;
	logic [PW-1:0] den_e;

	always_comb begin
		arith = (func_q <= FN_DIV);
		is_cmp = (func_q >= FN_LT) && (func_q <= FN_NE);
		adz   = (ad_q == '0);
		bdz   = (bd_q == '0);
		bnz   = (bn_q == '0);
		bad   = adz || bdz || ((func_q == FN_DIV) && bnz);
		sbe   = (func_q == FN_SUB) ? ~b_sign_q : b_sign_q;
		p_ge  = (p_q >= q_q);
		sum   = {1'b0, p_q} + {1'b0, q_q};
		diff  = p_ge ? {1'b0, p_q - q_q} : {1'b0, q_q - p_q};
		case (func_q)
			FN_ADD, FN_SUB: begin
				den_e = d_q;
				if (a_sign_q == sbe) begin
					num_e = sum;
					s_e   = a_sign_q;
				end else begin
					num_e = diff;
					s_e   = p_ge ? a_sign_q : sbe;
				end
			end
			FN_MUL: begin
				num_e = {1'b0, m_q};
				den_e = d_q;
				s_e   = a_sign_q ^ b_sign_q;
			end
			default: begin
				num_e = {1'b0, p_q};
				den_e = q_q;
				s_e   = a_sign_q ^ b_sign_q;
			end
		endcase
		ln   = a_sign_q && (p_q != '0);
		rneg = b_sign_q && (q_q != '0);
		eq   = (ln == rneg) && (p_q == q_q);
		if (ln != rneg) begin
			lt = ln;
		end else if (ln) begin
			lt = (p_q > q_q);
		end else begin
			lt = (p_q < q_q);
		end
		case (func_q)
			FN_LT:   cmp = lt;
			FN_LE:   cmp = lt || eq;
			FN_GT:   cmp = !lt && !eq;
			FN_GE:   cmp = !lt;
			FN_EQ:   cmp = eq;
			FN_NE:   cmp = !eq;
			default: cmp = 1'b0;
		endcase
		short_res = !arith || bad || (num_e == '0);
	end

	logic [NW:0]   trial;
	logic          fits;

	always_comb begin
		trial = {rem_q, dvd_q[NW-1]};
		fits  = (trial >= {1'b0, g_q});
	end

	assign sts.short_res = short_res;
	assign sts.gcd_done  = (u_q == '0) || (v_q == '0);
	assign sts.div_last  = (cnt_q == CW'(NW - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			a_sign_q <= a_sign;
			b_sign_q <= b_sign;
			an_q     <= a_num[W-1:0];
			ad_q     <= a_den[W-1:0];
			bn_q     <= b_num[W-1:0];
			bd_q     <= b_den[W-1:0];
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MS_P:    p_q <= prod;
				MS_Q:    q_q <= prod;
				MS_M:    m_q <= prod;
				default: d_q <= prod;
			endcase
		end
		if (cmd.eval) begin
			num_q     <= num_e;
			den_q     <= den_e;
			u_q       <= num_e;
			v_q       <= {1'b0, den_e};
			k_q       <= '0;
			f_sign_q  <= (arith && !bad && (num_e != '0)) ? s_e : 1'b0;
			f_num_q   <= '0;
			f_den_q   <= (arith && !bad && (num_e == '0)) ? PW'(1) : '0;
			f_cmp_q   <= cmp;
			f_undef_q <= arith ? bad : (is_cmp && (adz || bdz));
		end
		if (cmd.gcd_step) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= (u_q - v_q) >> 1;
			end else begin
				v_q <= (v_q - u_q) >> 1;
			end
		end
		if (cmd.shift_g) begin
			g_q <= (u_q | v_q) << k_q;
		end
		if (cmd.div_init_num || cmd.div_init_den) begin
			rem_q <= '0;
			cnt_q <= '0;
			dvd_q <= cmd.div_init_num ? num_q : {1'b0, den_q};
		end else if (cmd.div_step) begin
			rem_q <= fits ? NW'(trial - {1'b0, g_q}) : trial[NW-1:0];
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[NW-2:0], fits};
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.div_init_den) begin
			f_num_q <= quo_q;
		end
		if (cmd.save_den) begin
			f_den_q <= quo_q[PW-1:0];
		end
		if (cmd.load_out) begin
			o_sign_q  <= f_sign_q;
			o_num_q   <= f_num_q;
			o_den_q   <= f_den_q;
			o_cmp_q   <= f_cmp_q;
			o_undef_q <= f_undef_q;
		end
	end

	assign res_sign  = o_sign_q;
	assign res_num   = 63'(o_num_q);
	assign res_den   = 62'(o_den_q);
	assign cmp_true  = o_cmp_q;
	assign undefined = o_undef_q;

endmodule
`default_nettype wire

// ===== hdl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit for sign-magnitude fractions.
// The operands channel carries one operation code and two fractions; each
// transfer on it yields exactly one transfer on the result channel.
// Arithmetic codes give a result reduced by the greatest common divisor,
// comparison codes give only the comparison flag and the undefined flag.
// An item takes four steps on the shared multiplier and one evaluation step.
// Comparisons, other non-arithmetic codes, undefined and zero results then go
// straight to the output stage. Other arithmetic items first run the binary
// GCD loop and two restoring divisions by the GCD, of the numerator and then
// of the denominator.
// One item is worked on at a time; operands ready is high only while idle.
// The result sits in an output register, so the next item may be accepted
// and computed while an earlier result waits for the receiver; a finished
// item then waits until that register is free.
// Reset clears the controller and the result valid flag; no result is
// pending afterwards.
`default_nettype none
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int MAG_BITS = MAG_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rau_in_if.sink     operands,
	rau_out_if.source  result
);

	rau_cmd_t cmd;
	rau_sts_t sts;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.in_ready  (operands.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rau_dp #(
		.MAG_BITS (MAG_BITS)
	) u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.sts       (sts),
		.func      (operands.func),
		.a_sign    (operands.a_sign),
		.a_num     (operands.a_num),
		.a_den     (operands.a_den),
		.b_sign    (operands.b_sign),
		.b_num     (operands.b_num),
		.b_den     (operands.b_den),
		.res_sign  (result.res_sign),
		.res_num   (result.res_num),
		.res_den   (result.res_den),
		.cmp_true  (result.cmp_true),
		.undefined (result.undefined)
	);

endmodule
`default_nettype wire

// ===== hdl/rau_checker.sv =====
`default_nettype none
module rau_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        res_sign,
	input wire logic [62:0] res_num,
	input wire logic [61:0] res_den,
	input wire logic        cmp_true,
	input wire logic        undefined
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_num) && $stable(res_den))
		else $error("result changed while stalled");

	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmp_true |-> res_num == '0 && res_den == '0 && !res_sign)
		else $error("comparison result carries arithmetic fields");

	a_sign_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_sign |-> res_num != '0 && res_den != '0 && !undefined)
		else $error("negative sign on a zero or undefined result");

	a_zero_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_num == '0 && res_den != '0 |-> res_den == 62'd1 && !undefined)
		else $error("zero result not given as zero over one");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.res_sign  (result.res_sign),
	.res_num   (result.res_num),
	.res_den   (result.res_den),
	.cmp_true  (result.cmp_true),
	.undefined (result.undefined)
);
`default_nettype wire

// ===== tb/tb_rational_arithmetic_unit.sv =====
`default_nettype none
module tb_rational_arithmetic_unit
	import rau_pkg::*;
();

	localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

	typedef struct {
		logic        sign;
		logic [62:0] num;
		logic [61:0] den;
		logic        cmp;
		logic        undef;
	} fraction_res_t;

	logic clk;
	logic arst_n;
	logic calm;
	int   errors;
	int   sent;
	int   checked;
	int   undef_seen;
	int   cmp_seen;
	fraction_res_t expected_q[$];

	rau_in_if  operands();
	rau_out_if result();

	rational_arithmetic_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands.sink),
		.result   (result.source)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic fraction_res_t reduce_fraction(logic [3:0] fn, logic sa, logic [30:0] an,
			logic [30:0] ad, logic sb, logic [30:0] bn, logic [30:0] bd);
		fraction_res_t r;
		logic [63:0] p, q, num, den, g;
		logic        s, sbe;
		longint      l, rr;
		r = '{1'b0, '0, '0, 1'b0, 1'b0};
		p = 64'(an) * 64'(bd);
		q = 64'(bn) * 64'(ad);
		if (fn <= FN_DIV) begin
			if (ad == 0 || bd == 0 || (fn == FN_DIV && bn == 0)) begin
				r.undef = 1'b1;
			end else begin
				if (fn <= FN_SUB) begin
					sbe = (fn == FN_SUB) ? ~sb : sb;
					den = 64'(ad) * 64'(bd);
					if (sa == sbe) begin
						num = p + q;
						s = sa;
					end else if (p >= q) begin
						num = p - q;
						s = sa;
					end else begin
						num = q - p;
						s = sbe;
					end
				end else if (fn == FN_MUL) begin
					num = 64'(an) * 64'(bn);
					den = 64'(ad) * 64'(bd);
					s = sa ^ sb;
				end else begin
					num = p;
					den = q;
					s = sa ^ sb;
				end
				if (num == 0) begin
					r.den = 62'd1;
				end else begin
					g = gcd64(num, den);
					r.sign = s;
					r.num = 63'(num / g);
					r.den = 62'(den / g);
				end
			end
		end else if (fn <= FN_NE) begin
			l = sa ? -longint'(p) : longint'(p);
			rr = sb ? -longint'(q) : longint'(q);
			r.undef = (ad == 0 || bd == 0);
			case (fn)
				FN_LT: r.cmp = l < rr;
				FN_LE: r.cmp = l <= rr;
				FN_GT: r.cmp = l > rr;
				FN_GE: r.cmp = l >= rr;
				FN_EQ: r.cmp = l == rr;
				default: r.cmp = l != rr;
			endcase
		end
		return r;
	endfunction

	task automatic send_operation(logic [3:0] fn, logic sa, logic [30:0] an, logic [30:0] ad,
			logic sb, logic [30:0] bn, logic [30:0] bd);
		while (!calm && $urandom_range(99) < 38) begin
			operands.valid <= 1'b0;
			@(posedge clk);
		end
		operands.valid  <= 1'b1;
		operands.func   <= fn;
		operands.a_sign <= sa;
		operands.a_num  <= an;
		operands.a_den  <= ad;
		operands.b_sign <= sb;
		operands.b_num  <= bn;
		operands.b_den  <= bd;
		do @(posedge clk); while (!operands.ready);
		expected_q = {expected_q, reduce_fraction(fn, sa, an, ad, sb, bn, bd)};
		sent++;
	endtask

	function automatic logic [30:0] pick_mag(bit allow_zero);
		case ($urandom_range(9))
			0: return allow_zero ? 31'd0 : 31'd1;
			1: return MAG_MAX;
			2: return 31'd1;
			3, 4: return 31'($urandom_range(1, 30));
			5, 6: return 31'($urandom_range(1, 5000));
			default: return 31'($urandom) | (allow_zero ? 31'd0 : 31'd1);
		endcase
	endfunction

	task automatic send_random(logic [3:0] fn);
		logic [30:0] ad, bd;
		ad = ($urandom_range(99) < 4) ? 31'd0 : pick_mag(1'b0);
		bd = ($urandom_range(99) < 4) ? 31'd0 : pick_mag(1'b0);
		send_operation(fn, 1'($urandom), pick_mag(1'b1), ad, 1'($urandom), pick_mag(1'b1), bd);
	endtask

	always @(posedge clk) begin
		result.ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
	end

	always @(posedge clk) begin
		fraction_res_t e;
		if (arst_n && result.valid && result.ready) begin
			if (expected_q.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = expected_q.pop_front();
				checked++;
				if (e.undef) undef_seen++;
				if (e.cmp) cmp_seen++;
				if (result.res_sign !== e.sign) begin
					$error("res_sign expected %0h actual %0h", e.sign, result.res_sign);
					errors++;
				end
				if (result.res_num !== e.num) begin
					$error("res_num expected %0h actual %0h", e.num, result.res_num);
					errors++;
				end
				if (result.res_den !== e.den) begin
					$error("res_den expected %0h actual %0h", e.den, result.res_den);
					errors++;
				end
				if (result.cmp_true !== e.cmp) begin
					$error("cmp_true expected %0h actual %0h", e.cmp, result.cmp_true);
					errors++;
				end
				if (result.undefined !== e.undef) begin
					$error("undefined expected %0h actual %0h", e.undef, result.undefined);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_operation(FN_ADD, 1'b0, 31'd1, 31'd2, 1'b0, 31'd1, 31'd3);
		send_operation(FN_SUB, 1'b0, 31'd1, 31'd2, 1'b0, 31'd1, 31'd2);
		send_operation(FN_SUB, 1'b1, 31'd3, 31'd4, 1'b0, 31'd5, 31'd6);
		send_operation(FN_MUL, 1'b1, 31'd6, 31'd4, 1'b1, 31'd2, 31'd9);
		send_operation(FN_DIV, 1'b0, 31'd3, 31'd4, 1'b1, 31'd9, 31'd8);
		send_operation(FN_DIV, 1'b0, 31'd3, 31'd4, 1'b0, 31'd0, 31'd8);
		send_operation(FN_ADD, 1'b0, 31'd3, 31'd0, 1'b0, 31'd1, 31'd8);
		send_operation(FN_MUL, 1'b0, 31'd3, 31'd5, 1'b0, 31'd1, 31'd0);
		send_operation(FN_ADD, 1'b1, MAG_MAX, MAG_MAX, 1'b1, MAG_MAX, MAG_MAX);
		send_operation(FN_ADD, 1'b1, MAG_MAX, 31'd1, 1'b1, MAG_MAX, 31'd1);
		send_operation(FN_MUL, 1'b0, MAG_MAX, 31'd1, 1'b1, MAG_MAX, 31'd1);
		send_operation(FN_DIV, 1'b1, MAG_MAX, 31'd1, 1'b0, 31'd1, MAG_MAX);
		send_operation(FN_MUL, 1'b1, 31'd0, 31'd7, 1'b0, 31'd5, 31'd3);
		send_operation(FN_LT, 1'b1, 31'd1, 31'd2, 1'b0, 31'd1, 31'd3);
		send_operation(FN_LE, 1'b0, 31'd2, 31'd4, 1'b0, 31'd1, 31'd2);
		send_operation(FN_GT, 1'b1, 31'd0, 31'd4, 1'b0, 31'd0, 31'd2);
		send_operation(FN_GE, 1'b0, 31'd5, 31'd0, 1'b0, 31'd1, 31'd2);
		send_operation(FN_EQ, 1'b1, 31'd0, 31'd3, 1'b0, 31'd0, 31'd9);
		send_operation(FN_NE, 1'b1, MAG_MAX, MAG_MAX, 1'b0, MAG_MAX, MAG_MAX);
		send_operation(4'd10, 1'b1, 31'd3, 31'd4, 1'b1, 31'd5, 31'd6);
		send_operation(4'd15, 1'b1, MAG_MAX, MAG_MAX, 1'b1, MAG_MAX, MAG_MAX);
	endtask

	task automatic test_drain_pause();
		send_operation(FN_DIV, 1'b1, 31'd12345, 31'd678, 1'b0, 31'd91, 31'd1011);
		operands.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		send_operation(FN_ADD, 1'b0, 31'd7, 31'd9, 1'b1, 31'd11, 31'd13);
	endtask

	task automatic test_random_mix(int count);
		repeat (count) begin
			if ($urandom_range(99) < 5)
				send_random(4'($urandom_range(10, 15)));
			else if ($urandom_range(99) < 60)
				send_random(4'($urandom_range(0, 3)));
			else
				send_random(4'($urandom_range(4, 9)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		errors = 0;
		sent = 0;
		checked = 0;
		undef_seen = 0;
		cmp_seen = 0;
		operands.valid = 1'b0;
		operands.func = FN_ADD;
		operands.a_sign = 1'b0;
		operands.a_num = '0;
		operands.a_den = '0;
		operands.b_sign = 1'b0;
		operands.b_num = '0;
		operands.b_den = '0;
		result.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain_pause();
		test_random_mix(200);
		calm = 1'b1;
		test_random_mix(80);
		calm = 1'b0;
		test_random_mix(150);
		operands.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d operations, %0d results checked, %0d undefined, %0d true compares.",
			sent, checked, undef_seen, cmp_seen);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#60000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/rau_pkg.sv
hdl/rau_in_if.sv
hdl/rau_out_if.sv
hdl/rau_ctrl.sv
hdl/rau_dp.sv
hdl/rational_arithmetic_unit.sv
hdl/rau_checker.sv
tb/tb_rational_arithmetic_unit.sv
